// ----- sv/lef_pkg.sv -----
// ----------------------------------------------------------------------------
// lef_pkg: shared types and constants of the Laplacian edge filter
// Pixel word, config bundle and the command word passed front to back.
// ----------------------------------------------------------------------------
package lef_pkg;

  localparam int APB_ADDR_W = 3;
  // column field of a command; covers line buffers of up to 4096 pixels
  localparam int COL_W = 12;

  localparam logic OP_PIXEL = 1'b0;

  // red in [7:0], green in [15:8], blue in [23:16]
  typedef logic [23:0] pix_t;

  typedef enum logic {
    CMD_PIXEL,
    CMD_TAIL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              emit;
    logic              border;
    logic              last;
    logic              tail_prev;
    logic [COL_W-1:0]  col;
    pix_t              pix;
  } cmd_t;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [11:0] frame_height;
    logic        restart;
  } cfg_t;

endpackage

// ----- sv/lef_stream_if.sv -----
// ----------------------------------------------------------------------------
// lef_stream_if: pixel and result channels of the Laplacian edge filter
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lef_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;

  modport source (output valid, opcode, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, opcode, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface lef_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_last;

  modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

// ----- sv/lef_cfg.sv -----
// ----------------------------------------------------------------------------
// lef_cfg: APB register file of the Laplacian edge filter
// Holds frame width and height; any write restarts the frame counters.
// ----------------------------------------------------------------------------
module lef_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lef_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output lef_pkg::cfg_t                  cfg
);
  import lef_pkg::*;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  logic [10:0] frame_width;
  logic [11:0] frame_height;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 11'd640;
      frame_height <= 12'd500;
    end else if (wr) begin
      if (paddr[2] == REG_WIDTH) begin
        frame_width <= pwdata[10:0];
      end else begin
        frame_height <= pwdata[11:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? {20'd0, frame_height} : {21'd0, frame_width};

  assign cfg.frame_width  = frame_width;
  assign cfg.frame_height = frame_height;
  assign cfg.restart      = wr;

endmodule

// ----- sv/lef_front.sv -----
// ----------------------------------------------------------------------------
// lef_front: input side of the Laplacian edge filter
// Tracks input and output frame positions, classifies each beat and issues
// one command per pixel or pending tail result.
// ----------------------------------------------------------------------------
module lef_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  lef_pkg::cfg_t cfg,
  lef_in_if.sink        pixels,
  input  logic          q_full,
  output logic          q_push,
  output lef_pkg::cmd_t q_cmd
);
  import lef_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [12:0]   fw_ext;
  logic [12:0]   w_clamp;
  logic [WW-1:0] w_eff;
  logic [11:0]   h_eff;
  logic [CW-1:0] in_col;
  logic [CW-1:0] out_col;
  logic [11:0]   in_row;
  logic [11:0]   out_row;
  logic [CW:0]   in_col_inc;
  logic [CW:0]   out_col_inc;
  logic          accept;
  logic          is_pix;
  logic          is_tail;
  logic          emit;
  logic          in_col_wrap;
  logic          out_col_wrap;
  logic          out_row_end;
  logic          last;

  assign fw_ext  = 13'(cfg.frame_width);
  assign w_clamp = (fw_ext < 13'd3) ? 13'd3 :
                   ((int'(fw_ext) > MAX_WIDTH) ? 13'(MAX_WIDTH) : fw_ext);
  assign w_eff   = WW'(w_clamp);
  assign h_eff   = (cfg.frame_height < 12'd3) ? 12'd3 : cfg.frame_height;

  assign pixels.ready = !q_full;
  assign accept       = pixels.valid && pixels.ready;

  assign is_pix  = (pixels.opcode == OP_PIXEL) && (in_row < h_eff);
  assign is_tail = !is_pix && (in_row >= h_eff);
  assign emit    = is_tail ||
                   (is_pix && ((in_row >= 12'd2) || ((in_row == 12'd1) && (in_col != '0))));

  assign in_col_inc   = (CW+1)'(in_col) + (CW+1)'(1);
  assign out_col_inc  = (CW+1)'(out_col) + (CW+1)'(1);
  assign in_col_wrap  = in_col_inc >= w_eff;
  assign out_col_wrap = out_col_inc >= w_eff;
  assign out_row_end  = (13'(out_row) + 13'd1) >= 13'(h_eff);
  assign last         = out_row_end && out_col_wrap;

  assign q_push           = accept && (is_pix || is_tail);
  assign q_cmd.kind       = is_tail ? CMD_TAIL : CMD_PIXEL;
  assign q_cmd.emit       = emit;
  assign q_cmd.border     = (out_row == '0) || out_row_end || (out_col == '0) || out_col_wrap;
  assign q_cmd.last       = last;
  assign q_cmd.tail_prev  = out_row_end;
  assign q_cmd.col        = is_tail ? COL_W'(out_col) : COL_W'(in_col);
  assign q_cmd.pix        = {pixels.pixel_blue, pixels.pixel_green, pixels.pixel_red};

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (accept) begin
      if (is_pix) begin
        if (in_col_wrap) begin
          in_col <= '0;
          in_row <= in_row + 12'd1;
        end else begin
          in_col <= in_col_inc[CW-1:0];
        end
      end
      if (emit) begin
        if (last) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end else if (out_col_wrap) begin
          out_col <= '0;
          out_row <= out_row + 12'd1;
        end else begin
          out_col <= out_col_inc[CW-1:0];
        end
      end
    end
  end

  a_in_col_range: assert property (@(posedge clk) disable iff (rst)
    (CW+1)'(in_col) < w_eff)
    else $error("input column beyond frame width");

  a_out_pos_range: assert property (@(posedge clk) disable iff (rst)
    ((CW+1)'(out_col) < w_eff) && (out_row < h_eff))
    else $error("output position beyond frame");

endmodule

// ----- sv/lef_queue.sv -----
// ----------------------------------------------------------------------------
// lef_queue: command queue between front and back of the edge filter
// Four-entry circular buffer; head is presented combinationally.
// ----------------------------------------------------------------------------
module lef_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lef_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output lef_pkg::cmd_t head_cmd
);
  import lef_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full       = count == (PW+1)'(DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && !head_valid))
    else $error("queue over- or underflow");

endmodule

// ----- sv/lef_back.sv -----
// ----------------------------------------------------------------------------
// lef_back: execution side of the Laplacian edge filter
// Two line buffers with write-first bypass, the 3x3 window, the filter and
// the output register.
// ----------------------------------------------------------------------------
module lef_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  lef_pkg::cmd_t q_cmd,
  input  logic          q_valid,
  output logic          q_pop,
  lef_out_if.source     results
);
  import lef_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  function automatic pix_t laplace(input pix_t [8:0] win);
    logic [10:0]        nsum;
    logic signed [12:0] acc;
    pix_t               res;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      nsum = '0;
      for (int k = 0; k < 9; k++) begin
        if (k != 4) begin
          nsum = nsum + 11'(win[k][ch*8 +: 8]);
        end
      end
      acc = $signed({2'b00, win[4][ch*8 +: 8], 3'b000}) - $signed({2'b00, nsum});
      if (acc < 0) begin
        res[ch*8 +: 8] = 8'd0;
      end else if (acc > 13'sd255) begin
        res[ch*8 +: 8] = 8'd255;
      end else begin
        res[ch*8 +: 8] = acc[7:0];
      end
    end
    return res;
  endfunction

  pix_t          prev_mem  [MAX_WIDTH];
  pix_t          prev2_mem [MAX_WIDTH];
  pix_t          rd_prev;
  pix_t          rd_prev2;
  cmd_t          s1;
  logic          s1_valid;
  logic          s1_fire;
  pix_t [8:0]    window;
  pix_t [8:0]    win_next;
  pix_t          val;
  logic [CW-1:0] ra;
  logic [CW-1:0] wa;
  logic          wr_en;

  assign s1_fire = s1_valid && (!results.valid || results.ready);
  assign q_pop   = q_valid && (!s1_valid || s1_fire);
  assign ra      = q_cmd.col[CW-1:0];
  assign wa      = s1.col[CW-1:0];
  assign wr_en   = s1_fire && (s1.kind == CMD_PIXEL);

  // window rows: top from two rows up, middle from row above, bottom new
  always_comb begin
    win_next[0] = window[1];
    win_next[1] = window[2];
    win_next[2] = rd_prev2;
    win_next[3] = window[4];
    win_next[4] = window[5];
    win_next[5] = rd_prev;
    win_next[6] = window[7];
    win_next[7] = window[8];
    win_next[8] = s1.pix;
  end

  always_comb begin
    if (s1.kind == CMD_TAIL) begin
      val = s1.tail_prev ? rd_prev : rd_prev2;
    end else if (s1.border) begin
      val = win_next[4];
    end else begin
      val = laplace(win_next);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prev_mem[wa]  <= s1.pix;
      prev2_mem[wa] <= rd_prev;
    end
    if (q_pop) begin
      rd_prev  <= (wr_en && (wa == ra)) ? s1.pix  : prev_mem[ra];
      rd_prev2 <= (wr_en && (wa == ra)) ? rd_prev : prev2_mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1 <= q_cmd;
    end
    if (wr_en) begin
      window <= win_next;
    end
    if (s1_fire && s1.emit) begin
      results.out_red    <= val[7:0];
      results.out_green  <= val[15:8];
      results.out_blue   <= val[23:16];
      results.frame_last <= s1.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire && s1.emit) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  a_emit_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1.emit) |=> (results.valid && (results.frame_last == $past(s1.last))))
    else $error("issued result missing at output");

endmodule

// ----- sv/laplacian_edge_filter_core.sv -----
// ----------------------------------------------------------------------------
// Path: a result beat passes the queue, register s1 and the output register
// once the beat that releases it is accepted; results lag the pixels by one
// row plus one. Throughput: one beat per cycle while the output is not
// stalled, set by the read-modify-write of the two back-stage line buffers.
// Reset (rst, synchronous): clears counters, queue and handshakes; frame
// size returns to 640 x 500. Line buffer contents are not cleared.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// laplacian_edge_filter_core: streaming 3x3 Laplacian edge filter, RGB
// Front classifies beats, a short queue decouples it from the back, which
// holds the line buffers, the window and the output register.
// ----------------------------------------------------------------------------
module laplacian_edge_filter_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  lef_in_if.sink                         pixels,
  lef_out_if.source                      results,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lef_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import lef_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic full;
  logic pop;
  logic head_valid;

  lef_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lef_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pixels (pixels),
    .q_full (full),
    .q_push (push),
    .q_cmd  (push_cmd)
  );

  lef_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  lef_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_cmd   (head_cmd),
    .q_valid (head_valid),
    .q_pop   (pop),
    .results (results)
  );

endmodule
